FILE: sv/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigWords   = 8;

  localparam int unsigned CntW   = $clog2(BlockWords);
  localparam int unsigned RoundW = $clog2(Rounds);
  localparam int unsigned DigW   = $clog2(DigWords);

  localparam logic [CntW-1:0]   LastWordCnt  = CntW'(BlockWords - 1);
  localparam logic [RoundW-1:0] LastRound    = RoundW'(Rounds - 1);
  localparam logic [DigW-1:0]   LastDigIdx   = DigW'(DigWords - 1);

  // round constants
  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam logic [WordW-1:0] InitHash [DigWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             restart;
  } sha256_in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [DigW-1:0]  word_index;
    logic             last_word;
  } sha256_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha256_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic              take_word;
    logic              restart;
    logic              load_vars;
    logic              do_round;
    logic [RoundW-1:0] round_idx;
    logic              add_chain;
    logic [DigW-1:0]   out_idx;
  } sha256_cmd_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: sv/sha256_ctrl.sv
`timescale 1ns / 1ps
module sha256_ctrl import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_restart_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sha256_cmd_t cmd_o
);

  sha256_state_e     state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [DigW-1:0]   oidx_q, oidx_d;
  logic              in_acc, out_acc, block_full;

  assign in_acc     = in_valid_i && (state_q == ST_LOAD);
  assign out_acc    = out_ready_i && (state_q == ST_OUT);
  // a restart request always opens a new block, so it can never complete one
  assign block_full = !in_restart_i && (cnt_q == LastWordCnt);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && block_full) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == LastRound) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc && (oidx_q == LastDigIdx)) state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // counters
  always_comb begin
    cnt_d  = cnt_q;
    rnd_d  = rnd_q;
    oidx_d = oidx_q;
    if (in_acc) begin
      cnt_d = in_restart_i ? CntW'(1) : cnt_q + CntW'(1);
    end
    if (state_q == ST_ROUND) begin
      rnd_d = rnd_q + RoundW'(1);
    end
    if (out_acc) begin
      oidx_d = oidx_q + DigW'(1);
    end
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o           = '0;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = oidx_q;
    case (state_q)
      ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.take_word = in_valid_i;
        cmd_o.restart   = in_valid_i && in_restart_i;
        cmd_o.load_vars = in_acc && block_full;
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

endmodule

FILE: sv/sha256_dp.sv
`timescale 1ns / 1ps
module sha256_dp import sha256_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha256_cmd_t      cmd_i,
  input  logic [WordW-1:0] word_i,
  output sha256_out_t      out_o
);

  logic [WordW-1:0] chain_q [DigWords];
  logic [WordW-1:0] win_q   [BlockWords];
  logic [WordW-1:0] vars_q  [DigWords];
  logic [WordW-1:0] w_next, t1, t2, ch, maj;

  // schedule expansion from fixed taps of the shift line
  assign w_next = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

  // one compression round
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + big_sig1(vars_q[4]) + ch + win_q[0] + RoundK[cmd_i.round_idx];
  assign t2  = big_sig0(vars_q[0]) + maj;

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DigWords; i++) chain_q[i] <= InitHash[i];
    end else if (cmd_i.restart) begin
      for (int i = 0; i < DigWords; i++) chain_q[i] <= InitHash[i];
    end else if (cmd_i.add_chain) begin
      for (int i = 0; i < DigWords; i++) chain_q[i] <= chain_q[i] + vars_q[i];
    end
  end

  // schedule window, oldest word at the bottom
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_word || cmd_i.do_round) begin
      for (int i = 0; i < BlockWords - 1; i++) win_q[i] <= win_q[i+1];
      win_q[BlockWords-1] <= cmd_i.do_round ? w_next : word_i;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      for (int i = 0; i < DigWords; i++) vars_q[i] <= chain_q[i];
    end else if (cmd_i.do_round) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end
  end

  // result word selection
  assign out_o.digest_word = chain_q[cmd_i.out_idx];
  assign out_o.word_index  = cmd_i.out_idx;
  assign out_o.last_word   = (cmd_i.out_idx == LastDigIdx);

endmodule

FILE: sv/sha256_block_compression_top.sv
`timescale 1ns / 1ps
// after the sixteenth word request, the rounds and then the add step run; the first
// digest word is offered; eight words follow one per cycle while the sink is ready
// no new block is taken until all eight digest words are handed over;
// rounds run on the single round unit, one round per cycle
// reset: chaining value returns to the initial hash, word and round counts to zero
module sha256_block_compression_top import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sha256_in_t  in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sha256_out_t out_req_o
);

  sha256_cmd_t cmd;

  // sequencer
  sha256_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_req_i.restart),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  // hash datapath
  sha256_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .word_i (in_req_i.message_word),
    .out_o  (out_req_o)
  );

  // input and output never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output both active");

  // last digest word handed over returns the block to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_req_o.last_word) |=> in_ready_o)
    else $error("not back to loading after last digest word");

  // a handed-over digest word that is not last is followed by the next index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_req_o.last_word) |=>
      (out_valid_o && (out_req_o.word_index == $past(out_req_o.word_index) + DigW'(1))))
    else $error("digest word order broken");

  // last flag only on the final index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last_word == (out_req_o.word_index == LastDigIdx)))
    else $error("last flag mismatch");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top import sha256_pkg::*; ();

  // round constants and initial hash, kept separately from the design
  localparam logic [31:0] KTable [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int TargetWords = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sha256_in_t  in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sha256_out_t out_req;

  sha256_block_compression_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending word requests and expected digest words
  sha256_in_t  word_queue [$];
  sha256_out_t digest_expect [$];

  // predictor state
  logic [31:0] chain_h [8];
  logic [31:0] block_buf [16];
  logic [3:0]  word_count;

  int mismatch_cnt = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int cycle_cnt = 0;
  logic sink_hold = 1'b0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sched_s0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sched_s1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_s0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] round_s1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  // 64 rounds over the collected block, folded into the chaining value
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    int k;
    for (k = 0; k < 16; k++) w[k] = block_buf[k];
    for (k = 16; k < 64; k++)
      w[k] = sched_s1(w[k-2]) + w[k-7] + sched_s0(w[k-15]) + w[k-16];
    for (k = 0; k < 8; k++) v[k] = chain_h[k];
    for (k = 0; k < 64; k++) begin
      t1 = v[7] + round_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + w[k] + KTable[k];
      t2 = round_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (k = 0; k < 8; k++) chain_h[k] = chain_h[k] + v[k];
  endtask

  // take one accepted word; the sixteenth yields eight digest words
  task automatic absorb_word(input sha256_in_t w);
    sha256_out_t exp_word;
    int k;
    if (w.restart) begin
      for (k = 0; k < 8; k++) chain_h[k] = IvWords[k];
      word_count = '0;
    end
    block_buf[word_count] = w.message_word;
    word_count = word_count + 4'd1;
    if (word_count == 4'd0) begin
      compress_block();
      for (k = 0; k < 8; k++) begin
        exp_word.digest_word = chain_h[k];
        exp_word.word_index  = DigW'(k);
        exp_word.last_word   = (k == 7);
        digest_expect.push_back(exp_word);
      end
    end
  endtask

  task automatic check_digest(input sha256_out_t got);
    sha256_out_t want;
    if (digest_expect.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected digest word %h index %0d last %0b",
                 got.digest_word, got.word_index, got.last_word);
    end else begin
      want = digest_expect.pop_front();
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                   want.digest_word, want.word_index, want.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [31:0] word, input logic rs);
    sha256_in_t item;
    item.message_word = word;
    item.restart      = rs;
    word_queue.push_back(item);
  endtask

  // driver: offers queued word requests, with a random gap after some of them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        absorb_word(in_req);
        sent_cnt++;
        send_gap = ((sent_cnt % 64) < 20) ? 0 : $urandom_range(0, 7);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_req   <= word_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long sink hold-off so the block fills up and stalls its input
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    sink_hold <= (cycle_cnt >= 800) && (cycle_cnt < 1300);
  end

  // monitor: checks each accepted digest word, random ready gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_digest(out_req);
        recv_cnt++;
        recv_wait = ((recv_cnt % 48) < 16) ? 0 : $urandom_range(0, 7);
      end
      if (sink_hold) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int k;
    int len;
    int n_items;
    logic mid_restart;
    for (k = 0; k < 8; k++) chain_h[k] = IvWords[k];
    for (k = 0; k < 16; k++) block_buf[k] = '0;
    word_count = '0;

    // first block with no restart: starts from the reset hash, extreme words
    for (k = 0; k < 16; k++)
      case (k % 4)
        0: push_word(32'hffffffff, 1'b0);
        1: push_word(32'h00000000, 1'b0);
        2: push_word(32'h80000000, 1'b0);
        default: push_word(32'h00000001, 1'b0);
      endcase
    // partial block then a restart in mid-block
    push_word(32'h12345678, 1'b0);
    push_word(32'hffffffff, 1'b0);
    push_word(32'h00000000, 1'b0);
    push_word(32'hffffffff, 1'b1);
    for (k = 1; k < 16; k++) push_word(rand_word(), 1'b0);
    // chained block, no restart
    for (k = 0; k < 16; k++) push_word(rand_word(), 1'b0);
    n_items = 51;
    mid_restart = 1'b0;

    // random blocks, some cut short by a restart
    while (n_items < TargetWords || mid_restart) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 15);
        for (k = 0; k < len; k++)
          push_word(rand_word(), (k == 0) && ($urandom_range(0, 1) == 1));
        n_items += len;
        mid_restart = 1'b1;
      end else begin
        for (k = 0; k < 16; k++)
          push_word(rand_word(), (k == 0) && (mid_restart || $urandom_range(0, 2) == 0));
        n_items += 16;
        mid_restart = 1'b0;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (digest_expect.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    if (mismatch_cnt == 0 && digest_expect.size() == 0) begin
      $display("** sha256_block_compression_top: PASSED **");
    end else begin
      $display("** sha256_block_compression_top: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("** sha256_block_compression_top: FAILED **");
    $finish;
  end

endmodule
